>>> rtl/core/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg: shared types and constants of the priority task queue
// Operation and status codes, sequencer states and store control group.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int ID_BITS_DEF       = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_SRCH_RD,
    S_SRCH_EV,
    S_SHF_RD,
    S_SHF_EV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

>>> rtl/core/ptq_store.sv
// ----------------------------------------------------------------------------
// ptq_store: entry store of the priority task queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptq_store #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = 4
) (
  input  logic                clk,
  input  ptq_pkg::mem_ctl_t   ctl,
  input  logic [ADDR_W-1:0]   rd_addr,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [WIDTH-1:0]    wr_data,
  output logic [WIDTH-1:0]    rd_data
);
  import ptq_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/ptq_seq.sv
// ----------------------------------------------------------------------------
// ptq_seq: operation sequencer of the priority task queue
// Walks the store one slot per read/evaluate pair through a single compare
// unit, shifting entries to open or close a gap.
// ----------------------------------------------------------------------------
module ptq_seq #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int ID_BITS       = 16,
  parameter int ADDR_W        = 4,
  parameter int CNT_W         = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  ptq_pkg::op_t                     op,
  input  logic [ID_BITS-1:0]               id,
  input  logic [PRIORITY_BITS-1:0]         prio,
  output logic                             ready,
  output logic                             res_valid,
  input  logic                             res_ready,
  output ptq_pkg::status_t                 res_status,
  output logic [ID_BITS-1:0]               res_id,
  output logic [PRIORITY_BITS-1:0]         res_prio,
  output logic [CNT_W-1:0]                 res_count,
  output ptq_pkg::mem_ctl_t                mem_ctl,
  output logic [ADDR_W-1:0]                rd_addr,
  output logic [ADDR_W-1:0]                wr_addr,
  output logic [ID_BITS+PRIORITY_BITS-1:0] wr_data,
  input  logic [ID_BITS+PRIORITY_BITS-1:0] rd_data
);
  import ptq_pkg::*;

  localparam int ENTRY_W = ID_BITS + PRIORITY_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t                   state, state_next;
  op_t                      op_r;
  logic [ID_BITS-1:0]       key_id;
  logic [PRIORITY_BITS-1:0] key_prio;
  logic [CNT_W-1:0]         idx;
  logic [CNT_W-1:0]         count;
  status_t                  status;
  logic [ID_BITS-1:0]       rid;
  logic [PRIORITY_BITS-1:0] rpr;

  logic [ADDR_W-1:0]        idx_a;
  logic [CNT_W-1:0]         idx_inc;
  logic [ENTRY_W-1:0]       new_entry;
  logic [ID_BITS-1:0]       rd_id;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic                     prio_lt;
  logic                     id_eq;
  logic                     hit;
  logic                     last;
  logic                     full;
  logic                     empty;

  assign idx_a     = idx[ADDR_W-1:0];
  assign idx_inc   = idx + CNT_W'(1);
  assign new_entry = {key_id, key_prio};
  assign rd_id     = rd_data[ENTRY_W-1:PRIORITY_BITS];
  assign rd_prio   = rd_data[PRIORITY_BITS-1:0];
  assign full      = (count == CAP_CNT);
  assign empty     = (count == '0);
  assign last      = (idx_inc == count);

  // shared compare unit
  assign prio_lt = (rd_prio < key_prio);
  assign id_eq   = (rd_id == key_id);
  assign hit     = (op_r == OP_POP) || id_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_INSERT: state_next = full ? S_DONE : S_INS_RD;
            OP_POP,
            OP_REMOVE: state_next = empty ? S_DONE : S_SRCH_RD;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_INS_RD:  state_next = (idx_a == '0) ? S_DONE : S_INS_EV;
      S_INS_EV:  state_next = prio_lt ? S_INS_RD : S_DONE;
      S_SRCH_RD: state_next = S_SRCH_EV;
      S_SRCH_EV: begin
        if (hit) begin
          state_next = S_SHF_RD;
        end else if (last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_SHF_RD:  state_next = (idx == count) ? S_DONE : S_SHF_EV;
      S_SHF_EV:  state_next = S_SHF_RD;
      S_DONE:    state_next = res_ready ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl   = '0;
    rd_addr   = idx_a;
    wr_addr   = idx_a;
    wr_data   = new_entry;
    ready     = (state == S_IDLE);
    res_valid = (state == S_DONE);
    case (state)
      S_INS_RD: begin
        if (idx_a == '0) begin
          mem_ctl.wr_en = 1'b1;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_a - ADDR_W'(1);
        end
      end
      S_INS_EV: begin
        mem_ctl.wr_en = 1'b1;
        wr_data       = prio_lt ? rd_data : new_entry;
      end
      S_SRCH_RD: begin
        mem_ctl.rd_en = 1'b1;
      end
      S_SHF_RD: begin
        mem_ctl.rd_en = (idx != count);
      end
      S_SHF_EV: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = idx_a - ADDR_W'(1);
        wr_data       = rd_data;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r     <= op;
            key_id   <= id;
            key_prio <= prio;
            rid      <= '0;
            rpr      <= '0;
            idx      <= (op == OP_INSERT) ? count : '0;
            case (op)
              OP_INSERT: begin
                status <= full ? ST_FULL : ST_OK;
              end
              OP_POP,
              OP_REMOVE: begin
                status <= empty ? ST_EMPTY : ST_OK;
              end
              default: begin
                status <= ST_OK;
                count  <= '0;
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (idx_a == '0) begin
            count <= count + CNT_W'(1);
          end
        end
        S_INS_EV: begin
          if (prio_lt) begin
            idx <= idx - CNT_W'(1);
          end else begin
            count <= count + CNT_W'(1);
          end
        end
        S_SRCH_EV: begin
          if (hit) begin
            rid <= rd_id;
            rpr <= rd_prio;
            idx <= idx_inc;
          end else if (last) begin
            status <= ST_NOT_FOUND;
          end else begin
            idx <= idx_inc;
          end
        end
        S_SHF_RD: begin
          if (idx == count) begin
            count <= count - CNT_W'(1);
          end
        end
        S_SHF_EV: begin
          idx <= idx_inc;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  assign res_status = status;
  assign res_id     = rid;
  assign res_prio   = rpr;
  assign res_count  = count;

endmodule

>>> rtl/core/priority_task_queue.sv
// ----------------------------------------------------------------------------
// priority_task_queue: sorted-list priority queue
// Insert walks from the tail toward the head; pop and remove search from the
// head and then shift the later entries up; clear only resets the occupancy.
// One operation at a time, set by the walk of the entry store (one read and
// one evaluate step per slot visited; the store has one read and one write port).
// Reset (rst, synchronous, active high) empties the queue and drops any
// pending result; the store contents need no clearing.
// ----------------------------------------------------------------------------
module priority_task_queue #(
  parameter int CAPACITY      = ptq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = ptq_pkg::PRIORITY_BITS_DEF,
  parameter int ID_BITS       = ptq_pkg::ID_BITS_DEF,
  localparam int ADDR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W        = $clog2(CAPACITY + 1),
  localparam int IN_DATA_W    = ((ID_BITS + PRIORITY_BITS + 7) / 8) * 8,
  localparam int OUT_FIELDS_W = ID_BITS + PRIORITY_BITS + CNT_W,
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // task_id [ID_BITS-1:0], task_priority above it, zero padded
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // removed_id, removed_priority, occupancy from the lowest bit up, zero padded
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]            m_axis_tuser
);
  import ptq_pkg::*;

  localparam int ENTRY_W = ID_BITS + PRIORITY_BITS;

  logic                     start;
  logic                     seq_ready;
  logic                     res_valid;
  logic                     res_ready;
  status_t                  res_status;
  logic [ID_BITS-1:0]       res_id;
  logic [PRIORITY_BITS-1:0] res_prio;
  logic [CNT_W-1:0]         res_count;
  mem_ctl_t                 mem_ctl;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ENTRY_W-1:0]       wr_data;
  logic [ENTRY_W-1:0]       rd_data;

  // output register contents
  status_t                  out_status;
  logic [ID_BITS-1:0]       out_id;
  logic [PRIORITY_BITS-1:0] out_prio;
  logic [CNT_W-1:0]         out_count;

  // Take a new operation only while the sequencer is idle; a finished result
  // may still sit in the output register meanwhile.
  assign s_axis_tready = seq_ready;
  assign start         = s_axis_tvalid && seq_ready;

  // The output register is free when empty or being drained this cycle.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  ptq_seq #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .ID_BITS       (ID_BITS),
    .ADDR_W        (ADDR_W),
    .CNT_W         (CNT_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op_t'(s_axis_tuser)),
    .id         (s_axis_tdata[ID_BITS-1:0]),
    .prio       (s_axis_tdata[ENTRY_W-1:ID_BITS]),
    .ready      (seq_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_id     (res_id),
    .res_prio   (res_prio),
    .res_count  (res_count),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data)
  );

  // Entries held as {id, priority}, head at slot 0.
  ptq_store #(
    .DEPTH  (CAPACITY),
    .WIDTH  (ENTRY_W),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Output register: load a result on its transfer from the sequencer,
  // hold it until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status <= res_status;
      out_id     <= res_id;
      out_prio   <= res_prio;
      out_count  <= res_count;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'({out_count, out_prio, out_id});
  assign m_axis_tuser = out_status;

endmodule
